/* rtl/ctdec_pkg.sv */
// ----------------------------------------------------------------------------
// CAN telemetry decoder package
// Shared types, identifiers and widths for the telemetry frame decoder.
// ----------------------------------------------------------------------------
package ctdec_pkg;

  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 192;
  localparam int unsigned CfgDataW = 12;

  localparam logic [28:0] IdBms   = 29'h155;
  localparam logic [28:0] IdMotor = 29'h196;
  localparam logic [28:0] IdCells = 29'h554;
  localparam logic [28:0] IdPack  = 29'h55F;
  localparam logic [28:0] IdSpeed = 29'h599;
  localparam logic [28:0] IdCtrl  = 29'h59E;

  localparam logic [3:0]  FullDlc     = 4'd8;
  localparam logic [7:0]  BmsOkCode   = 8'h54;
  localparam logic [15:0] SpeedInvalid = 16'hFFFF;
  localparam logic [11:0] CurrRawMask = 12'hFFF;
  localparam logic signed [12:0] CurrOffset = 13'sd2000;
  localparam logic signed [8:0]  TempOffset = 9'sd40;
  localparam logic signed [11:0] CellOffset = 12'sd280;

  localparam logic [CfgDataW-1:0] VoltMinReset = 12'd400;
  localparam logic [CfgDataW-1:0] VoltMaxReset = 12'd700;

  typedef enum logic {
    CfgVoltMin = 1'b0,
    CfgVoltMax = 1'b1
  } cfg_index_e;

  // known mask bit positions
  localparam int unsigned KVolt  = 0;
  localparam int unsigned KCurr  = 1;
  localparam int unsigned KPower = 2;
  localparam int unsigned KSoc   = 3;
  localparam int unsigned KSpeed = 4;
  localparam int unsigned KMotor = 5;
  localparam int unsigned KCtrl  = 6;
  localparam int unsigned KCell  = 7;

  typedef struct packed {
    logic              is_extended;
    logic [28:0]       frame_id;
    logic [3:0]        data_length;
    logic [7:0][7:0]   payload;     // payload[k] is byte k
    logic [31:0]       now_ms;
  } frame_t;

  typedef struct packed {
    logic [12:0]        volt;
    logic signed [12:0] curr;
    logic [15:0]        soc;
    logic [15:0]        speed;
    logic signed [8:0]  drive_temp;
    logic signed [8:0]  inverter_temp;
    logic signed [11:0] cell_sum;
    logic               bms_ok;
    logic [7:0]         known;
    logic [31:0]        frame_count;
    logic [31:0]        last_time;
  } snap_t;

  typedef struct packed {
    logic [CfgDataW-1:0] volt_min;
    logic [CfgDataW-1:0] volt_max;
  } cfg_t;

endpackage

/* rtl/can_telemetry_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// CAN telemetry frame decoder
// Decodes standard CAN frames into a vehicle telemetry snapshot.
// ----------------------------------------------------------------------------
// Each accepted frame beat yields one result beat with the whole snapshot.
// A frame passes an input register, then the decode logic and the
// voltage-times-current multiply into the result register. A new frame
// can be taken every cycle while the result side is not stalled; the
// snapshot register closes the loop from one frame to the next.
// Back-pressure on the result side stalls both registers.
// Configuration writes are always taken and should
// be issued only while no frame is in flight.
module can_telemetry_frame_decoder_top import ctdec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // frame_id[28:0], data_length[32:29], byte0..byte7[96:33], now_ms[128:97]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // is_extended[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pack_voltage[12:0], battery_current[25:13], battery_power[51:26],
  // charge_state[67:52], vehicle_speed[83:68], drive_temp[92:84],
  // inverter_temp[101:93], cell_temp_sum[113:102], bms_ok[114],
  // known_mask[122:115], frame_total[154:123], last_seen_ms[186:155]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t   cfg;
  frame_t frame_q, frame_d;
  logic   in_valid_q, in_valid_d;
  snap_t  snap_q, snap_d;
  logic   advance, s_fire, process;

  ctdec_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign process       = in_valid_q && advance;

  always_comb begin
    frame_d.is_extended = s_axis_tuser;
    frame_d.frame_id    = s_axis_tdata[28:0];
    frame_d.data_length = s_axis_tdata[32:29];
    frame_d.payload     = s_axis_tdata[96:33];
    frame_d.now_ms      = s_axis_tdata[128:97];
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  // byte k sits at s_axis_tdata[40+8k:33+8k], matching payload[k]
  ctdec_frame_decode u_decode (
    .frame_i (frame_q),
    .snap_i  (snap_q),
    .cfg_i   (cfg),
    .snap_o  (snap_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      snap_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (process) begin
        snap_q <= snap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      frame_q <= frame_d;
    end
  end

  ctdec_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (process),
    .snap_i        (snap_d),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* rtl/ctdec_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the plausibility window for the pack voltage readings.
// ----------------------------------------------------------------------------
module ctdec_cfg_regs import ctdec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgVoltMin: cfg_d.volt_min = cfg_data_i;
        CfgVoltMax: cfg_d.volt_max = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volt_min <= VoltMinReset;
      cfg_q.volt_max <= VoltMaxReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/ctdec_frame_decode.sv */
// ----------------------------------------------------------------------------
// Frame decoder
// Computes the next telemetry snapshot from one frame and the current one.
// ----------------------------------------------------------------------------
module ctdec_frame_decode import ctdec_pkg::*; (
  input  frame_t frame_i,
  input  snap_t  snap_i,
  input  cfg_t   cfg_i,
  output snap_t  snap_o
);

  logic [7:0]  b [8];
  logic        full;
  logic [11:0] curr_raw;
  logic [10:0] byte_sum;
  logic [11:0] v1, v2;
  logic        p1, p2;
  logic [15:0] speed_raw;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k] = frame_i.payload[k];
    end
  end

  assign full      = (frame_i.data_length == FullDlc);
  assign curr_raw  = {b[1][3:0], b[2]} & CurrRawMask;
  assign byte_sum  = 11'(b[0]) + 11'(b[1]) + 11'(b[2]) + 11'(b[3])
                   + 11'(b[4]) + 11'(b[5]) + 11'(b[6]);
  assign v1        = {b[5], b[6][7:4]};
  assign v2        = {b[6][3:0], b[7]};
  assign p1        = (v1 >= cfg_i.volt_min) && (v1 <= cfg_i.volt_max);
  assign p2        = (v2 >= cfg_i.volt_min) && (v2 <= cfg_i.volt_max);
  assign speed_raw = {b[6], b[7]};

  always_comb begin
    snap_o = snap_i;
    if (!frame_i.is_extended) begin
      snap_o.last_time   = frame_i.now_ms;
      snap_o.frame_count = snap_i.frame_count + 32'd1;
      if (full) begin
        case (frame_i.frame_id)
          IdBms: begin
            snap_o.curr   = CurrOffset - $signed({1'b0, curr_raw});
            snap_o.bms_ok = (b[3] == BmsOkCode);
            snap_o.soc    = {b[4], b[5]};
            snap_o.known[KCurr] = 1'b1;
            snap_o.known[KSoc]  = 1'b1;
          end
          IdMotor: begin
            snap_o.drive_temp   = $signed({1'b0, b[5]}) - TempOffset;
            snap_o.known[KMotor] = 1'b1;
          end
          IdCells: begin
            snap_o.cell_sum     = $signed({1'b0, byte_sum}) - CellOffset;
            snap_o.known[KCell] = 1'b1;
          end
          IdPack: begin
            if (p1 && p2) begin
              snap_o.volt = 13'(v1) + 13'(v2);
              snap_o.known[KVolt] = 1'b1;
            end else if (p1) begin
              snap_o.volt = {v1, 1'b0};
              snap_o.known[KVolt] = 1'b1;
            end else if (p2) begin
              snap_o.volt = {v2, 1'b0};
              snap_o.known[KVolt] = 1'b1;
            end
          end
          IdSpeed: begin
            if (speed_raw != SpeedInvalid) begin
              snap_o.speed = speed_raw;
              snap_o.known[KSpeed] = 1'b1;
            end
          end
          IdCtrl: begin
            snap_o.inverter_temp = $signed({1'b0, b[5]}) - TempOffset;
            snap_o.known[KCtrl]  = 1'b1;
          end
          default: snap_o.known = snap_o.known;
        endcase
      end
      snap_o.known[KPower] = snap_o.known[KVolt] & snap_o.known[KCurr];
    end
  end

endmodule

/* rtl/ctdec_out_stage.sv */
// ----------------------------------------------------------------------------
// Result stage
// Multiplies voltage by current and registers the packed result beat.
// ----------------------------------------------------------------------------
module ctdec_out_stage import ctdec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  snap_t               snap_i,
  input  logic                m_axis_tready,
  output logic                m_axis_tvalid,
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic                  valid_q, valid_d;
  logic [OutDataW-1:0]   data_q, data_d;
  logic signed [26:0]    product;
  logic signed [25:0]    power;

  assign product = $signed({1'b0, snap_i.volt}) * snap_i.curr;
  assign power   = snap_i.known[KPower] ? product[25:0] : 26'sd0;

  always_comb begin
    data_d = {5'd0,
              snap_i.last_time,
              snap_i.frame_count,
              snap_i.known,
              snap_i.bms_ok,
              snap_i.cell_sum,
              snap_i.inverter_temp,
              snap_i.drive_temp,
              snap_i.speed,
              snap_i.soc,
              power,
              snap_i.curr,
              snap_i.volt};
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

/* rtl/ctdec_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the decoder ports for handshake and snapshot consistency.
// ----------------------------------------------------------------------------
module ctdec_checker import ctdec_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic m_fire;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_power_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[117] == (m_axis_tdata[115] && m_axis_tdata[116]))
    else $error("power known bit disagrees with voltage and current");

  a_power_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[117] |-> m_axis_tdata[51:26] == 26'd0)
    else $error("power nonzero before it is known");

  a_known_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && $past(m_fire) |->
      (m_axis_tdata[122:115] & $past(m_axis_tdata[122:115])) ==
      $past(m_axis_tdata[122:115]))
    else $error("known bit dropped between beats");

endmodule

bind can_telemetry_frame_decoder_top ctdec_checker u_ctdec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
